/* sv/raised_cosine_velocity_smoother_assert.svh */
// Assertion macros shared by the raised-cosine velocity smoother RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef RAISED_COSINE_VELOCITY_SMOOTHER_ASSERT_SVH
`define RAISED_COSINE_VELOCITY_SMOOTHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCVS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rcvs_pkg.sv */
// Shared constants, types and the raised-cosine ratio table of the smoother.
// No dependencies; imported by every module of the block.
package rcvs_pkg;

    localparam int AXES              = 6;
    localparam int VEL_WIDTH         = 16;
    localparam int COS_TABLE_ENTRIES = 256;
    localparam int TICK_WIDTH        = 16;

    localparam int NUM_FIELDS = 6;
    localparam int DATA_W     = ((NUM_FIELDS * VEL_WIDTH + 7) / 8) * 8;

    localparam int VLIM_W   = 15;
    localparam int SMOOTH_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TICKS = 1'd1;
    localparam logic [VLIM_W-1:0]    VEL_LIMIT_RST    = 15'd4096;
    localparam logic [SMOOTH_W-1:0]  SMOOTH_RST       = 16'd1000;

    localparam int RATIO_W = 16;
    localparam int IDX_W   = $clog2(COS_TABLE_ENTRIES);
    localparam int CMP_W   = (TICK_WIDTH > SMOOTH_W) ? TICK_WIDTH : SMOOTH_W;
    localparam int NUM_W   = CMP_W + IDX_W;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_KEEP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SNAP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLEND = 2'd2;

    typedef struct packed {
        logic              load_cmd;
        logic              mul_en;
        logic              commit;
        logic [MODE_W-1:0] mode;
    } t_lane_ctl;

    typedef logic [NUM_FIELDS-1:0][VEL_WIDTH-1:0] t_vel_vec;
    typedef logic [RATIO_W-1:0] t_cos_tab [COS_TABLE_ENTRIES];

    localparam longint Q30    = longint'(1) <<< 30;
    localparam longint PI_Q30 = 64'sd3373259426;

    // Q0.16 value of 0.5*(1 - cos(pi*p/E)), Taylor series folded about pi/2.
    function automatic logic [RATIO_W-1:0] cos_ratio(input int p);
        longint dp;
        longint y;
        longint y2;
        longint h;
        longint c;
        longint r;
        bit     upper;
        upper = (2 * p > COS_TABLE_ENTRIES);
        dp    = upper ? longint'(COS_TABLE_ENTRIES - p) : longint'(p);
        y     = (PI_Q30 * dp) / COS_TABLE_ENTRIES;
        y2    = (y * y) >>> 30;
        h     = Q30 - y2 / 90;
        h     = Q30 - ((y2 * h) >>> 30) / 56;
        h     = Q30 - ((y2 * h) >>> 30) / 30;
        h     = Q30 - ((y2 * h) >>> 30) / 12;
        c     = Q30 - ((y2 * h) >>> 30) / 2;
        if (upper) begin
            c = -c;
        end
        r = Q30 - c + (longint'(1) <<< 14);
        if (r < 0) begin
            r = 0;
        end
        r = r >>> 15;
        if (r > 65535) begin
            r = 65535;
        end
        return r[RATIO_W-1:0];
    endfunction

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        for (int p = 0; p < COS_TABLE_ENTRIES; p++) begin
            tab[p] = cos_ratio(p);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

/* sv/rcvs_div.sv */
// Restoring divider for the table index floor(t*E/T), one quotient bit a cycle.
// Depends on rcvs_pkg.
module rcvs_div
    import rcvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMP_W-1:0] i_num,
    input  logic [CMP_W-1:0] i_den,
    output logic             o_done,
    output logic [IDX_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CMP_W-1:0] r_rem;
    logic [CMP_W-1:0] r_den;
    logic [IDX_W-1:0] r_low;
    logic [IDX_W-1:0] r_quot;

    logic [NUM_W-1:0] num_scaled;
    logic [CMP_W:0]   trial;
    logic [CMP_W:0]   den_ext;
    logic             ge;
    logic [CMP_W:0]   diff;
    logic [CMP_W-1:0] n_rem;

    // Numerator below T*E, so the high part starts below T.
    assign num_scaled = NUM_W'(i_num) * NUM_W'(COS_TABLE_ENTRIES);
    assign trial      = {r_rem, r_low[IDX_W-1]};
    assign den_ext    = {1'b0, r_den};
    assign ge         = (trial >= den_ext);
    assign diff       = trial - den_ext;
    assign n_rem      = ge ? diff[CMP_W-1:0] : trial[CMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(IDX_W);
                r_rem  <= num_scaled[NUM_W-1:IDX_W];
                r_low  <= num_scaled[IDX_W-1:0];
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_low  <= {r_low[IDX_W-2:0], 1'b0};
                r_quot <= {r_quot[IDX_W-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/rcvs_lane.sv */
// One axis of the smoother: clamp, target/start/current state and the blend.
// Depends on rcvs_pkg.
module rcvs_lane
    import rcvs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane_ctl            i_ctl,
    input  logic [VEL_WIDTH-1:0] i_cmd,
    input  logic [VEL_WIDTH-1:0] i_lim,
    input  logic [RATIO_W-1:0]   i_ratio,
    output logic [VEL_WIDTH-1:0] o_next
);

    localparam int EXT_W  = VEL_WIDTH + 1;
    localparam int PROD_W = EXT_W + RATIO_W + 1;
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W - RATIO_W){1'b0}}, 1'b1, {(RATIO_W - 1){1'b0}}};

    logic [VEL_WIDTH-1:0]     r_target;
    logic [VEL_WIDTH-1:0]     r_start;
    logic [VEL_WIDTH-1:0]     r_cur;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [EXT_W-1:0]  cmd_ext;
    logic signed [EXT_W-1:0]  lim_pos;
    logic signed [EXT_W-1:0]  lim_neg;
    logic signed [EXT_W-1:0]  clamped;
    logic signed [EXT_W-1:0]  tgt_ext;
    logic signed [EXT_W-1:0]  start_ext;
    logic signed [EXT_W-1:0]  diff;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] shifted;
    logic signed [EXT_W-1:0]  blended;
    logic [VEL_WIDTH-1:0]     n_cur;

    assign cmd_ext = $signed({i_cmd[VEL_WIDTH-1], i_cmd});
    assign lim_pos = $signed({1'b0, i_lim});
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (cmd_ext > lim_pos) begin
            clamped = lim_pos;
        end else if (cmd_ext < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = cmd_ext;
        end
    end

    assign tgt_ext   = $signed({r_target[VEL_WIDTH-1], r_target});
    assign start_ext = $signed({r_start[VEL_WIDTH-1], r_start});
    assign diff      = tgt_ext - start_ext;

    // Round half up: add one half, then an arithmetic shift floors.
    assign rounded = r_prod + HALF;
    assign shifted = rounded >>> RATIO_W;
    assign blended = start_ext + $signed(shifted[EXT_W-1:0]);

    always_comb begin
        unique case (i_ctl.mode)
            MODE_SNAP:  n_cur = r_target;
            MODE_BLEND: n_cur = blended[VEL_WIDTH-1:0];
            default:    n_cur = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_start  <= '0;
            r_cur    <= '0;
        end else begin
            if (i_ctl.load_cmd) begin
                r_target <= clamped[VEL_WIDTH-1:0];
                r_start  <= r_cur;
            end
            if (i_ctl.commit) begin
                r_cur <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= diff * $signed({1'b0, i_ratio});
        end
    end

    assign o_next = n_cur;

endmodule

/* sv/rcvs_merge.sv */
// Merging stage: packs the lane velocities and the blend flag into one result
// and holds it in the output register. Depends on rcvs_pkg.
module rcvs_merge
    import rcvs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_vel_vec          i_vel,
    input  logic              i_blend,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata,
    output logic              o_tuser
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_user;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= DATA_W'(i_vel);
            r_user <= i_blend;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

endmodule

/* sv/raised_cosine_velocity_smoother.sv */
// Raised-cosine velocity smoother for six velocity axes.
// Use: the slave stream carries one request per item. tuser = 1 is a new
// command: each axis in tdata is clamped to +/- vel_limit and becomes the
// target, the present output becomes the start, and the tick count clears.
// tuser = 0 is a control tick: the count advances and one result goes out on
// the master stream with all six axes in tdata and the blend flag in tuser.
// Configuration: i_cfg_we writes register i_cfg_idx (0 vel_limit Q3.12,
// 1 smoothing_ticks) at the clock edge; write only while the block is idle.
// Sequence: a command gives no result and leaves the block ready for the next
// request. A tick that blends runs the radix-2 index divider, one quotient bit
// per cycle, then the lane multiply, and then commits its result; the next
// request is taken only once that commit is done. A tick that holds or snaps
// skips the divider and the multiply and commits straight after the count check.
// All six lanes multiply side by side in the same cycle, then merge into one word.
// Reset: all velocities zero, no blend, vel_limit 4096, smoothing_ticks 1000.
// Stall: a result waits in the output register; a following request is still
// accepted and worked on, and its result is held back until the register frees.
// Depends on rcvs_pkg, rcvs_div, rcvs_lane, rcvs_merge and the assert header.
`include "raised_cosine_velocity_smoother_assert.svh"

module raised_cosine_velocity_smoother
    import rcvs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x, cmd_ang_y, cmd_ang_z
    input  logic [DATA_W-1:0]    i_s_axis_tdata,
    // action
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
    output logic [DATA_W-1:0]    o_m_axis_tdata,
    // blending
    output logic                 o_m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int CLIM_W = (VEL_WIDTH > VLIM_W) ? VEL_WIDTH : VLIM_W;
    localparam logic [VEL_WIDTH-1:0] VMAX = {1'b0, {(VEL_WIDTH - 1){1'b1}}};
    localparam logic [TICK_WIDTH-1:0] TMAX = '1;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [VLIM_W-1:0]     r_vel_limit;
    logic [SMOOTH_W-1:0]   r_smooth;
    logic [TICK_WIDTH-1:0] r_ticks;
    logic                  r_blend;
    logic                  n_blend;
    logic [MODE_W-1:0]     r_mode;
    logic [RATIO_W-1:0]    r_ratio;

    logic                  s_acc;
    logic                  out_free;
    logic                  div_start;
    logic                  div_done;
    logic [IDX_W-1:0]      div_quot;
    logic [CLIM_W-1:0]     vl_ext;
    logic [VEL_WIDTH-1:0]  lim;
    logic                  tick_done;
    logic                  commit;
    t_lane_ctl             lane_ctl;
    t_vel_vec              lane_next;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Limit above the velocity range acts as the largest positive velocity.
    assign vl_ext = CLIM_W'(r_vel_limit);
    assign lim    = (vl_ext > CLIM_W'(VMAX)) ? VMAX : vl_ext[VEL_WIDTH-1:0];

    assign tick_done = (CMP_W'(r_ticks) >= CMP_W'(r_smooth));
    assign div_start = (r_state == S_CHK) && r_blend && !tick_done;
    assign commit    = (r_state == S_OUT) && out_free;
    assign n_blend   = (r_mode == MODE_SNAP) ? 1'b0 : r_blend;

    assign lane_ctl.load_cmd = s_acc && i_s_axis_tuser;
    assign lane_ctl.mul_en   = (r_state == S_MUL);
    assign lane_ctl.commit   = commit;
    assign lane_ctl.mode     = r_mode;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_limit <= VEL_LIMIT_RST;
            r_smooth    <= SMOOTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VEL_LIMIT:    r_vel_limit <= i_cfg_wdata[VLIM_W-1:0];
                REG_SMOOTH_TICKS: r_smooth    <= i_cfg_wdata[SMOOTH_W-1:0];
                default:          r_smooth    <= r_smooth;
            endcase
        end
    end

    // Sequencer: check the count, divide for the table index and multiply on a blend, commit.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && !i_s_axis_tuser) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = div_start ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ticks <= '0;
            r_blend <= 1'b0;
            r_mode  <= MODE_KEEP;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                if (i_s_axis_tuser) begin
                    // New command: clear the count and start a blend.
                    r_ticks <= '0;
                    r_blend <= 1'b1;
                end else if (r_ticks != TMAX) begin
                    // Advance the count, hold it at the top.
                    r_ticks <= r_ticks + TICK_WIDTH'(1);
                end
            end
            if (r_state == S_CHK) begin
                priority if (!r_blend) begin
                    r_mode <= MODE_KEEP;
                end else if (tick_done) begin
                    r_mode <= MODE_SNAP;
                end else begin
                    r_mode <= MODE_BLEND;
                end
            end
            if (commit) begin
                r_blend <= n_blend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && div_done) begin
            r_ratio <= COS_TAB[div_quot];
        end
    end

    rcvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (CMP_W'(r_ticks)),
        .i_den   (CMP_W'(r_smooth)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    for (genvar a = 0; a < NUM_FIELDS; a++) begin : g_lane
        if (a < AXES) begin : g_on
            rcvs_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lane_ctl),
                .i_cmd   (i_s_axis_tdata[a*VEL_WIDTH +: VEL_WIDTH]),
                .i_lim   (lim),
                .i_ratio (r_ratio),
                .o_next  (lane_next[a])
            );
        end else begin : g_off
            // Drop unused command fields; the output field stays zero.
            assign lane_next[a] = '0;
        end
    end

    rcvs_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (commit),
        .i_vel    (lane_next),
        .i_blend  (n_blend),
        .o_free   (out_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

    `RCVS_ASSERT_NEXT(a_tick_enters_check, s_acc && !i_s_axis_tuser, r_state == S_CHK, "tick request did not enter the count check")
    `RCVS_ASSERT_IMPL(a_div_done_in_div, div_done, r_state == S_DIV, "divider finished outside the divide state")
    `RCVS_ASSERT_NEXT(a_commit_loads_output, commit, o_m_axis_tvalid && (r_state == S_IDLE), "commit did not present a result")
    `RCVS_ASSERT_NEXT(a_snap_ends_blend, commit && (r_mode == MODE_SNAP), !o_m_axis_tuser && !r_blend, "snap left the blend running")

endmodule
